>>> src/wrm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the wildcard regex matcher.
// No dependencies; used by wrm_cell and wildcard_regex_matcher_core.
package wrm_pkg;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] DOT_BYTE  = 8'h2E;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_TEXT   = 2'd2;
  localparam logic [1:0] FUNC_END    = 2'd3;

  localparam logic [2:0] CELL_HOLD   = 3'd0;
  localparam logic [2:0] CELL_CLEAR  = 3'd1;
  localparam logic [2:0] CELL_REARM  = 3'd2;
  localparam logic [2:0] CELL_STEP   = 3'd3;
  localparam logic [2:0] CELL_SETTLE = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] sym;
  } cell_ctrl_t;

endpackage

>>> src/wrm_cell.sv
`timescale 1ns / 1ps
// One pattern column: holds a pattern byte, its valid bit and its match bit.
// Depends on wrm_pkg.
module wrm_cell (
  input  logic              clk,
  input  logic              rst,
  input  wrm_pkg::cell_ctrl_t ctrl,
  input  logic              wr,
  input  logic [7:0]        prev_pat,
  input  logic              prev_hit,
  input  logic              prev2_hit,
  output logic [7:0]        pat,
  output logic              hit,
  output logic              changed
);
  import wrm_pkg::*;

  logic valid;
  logic is_star;
  logic rep_ok;
  logic lit_ok;
  logic step_hit;
  logic settle_hit;

  assign is_star    = (pat == STAR_BYTE);
  assign rep_ok     = (prev_pat == DOT_BYTE) || (prev_pat == ctrl.sym);
  assign lit_ok     = (pat == DOT_BYTE) || (pat == ctrl.sym);
  assign step_hit   = valid & (is_star ? (rep_ok & hit) : (lit_ok & prev_hit));
  assign settle_hit = hit | (valid & is_star & prev2_hit);
  assign changed    = (ctrl.op == CELL_SETTLE) && (settle_hit != hit);

  always_ff @(posedge clk) begin
    if (ctrl.op == CELL_REARM && wr) begin
      pat <= ctrl.sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      case (ctrl.op)
        CELL_CLEAR: begin
          valid <= 1'b0;
          hit   <= 1'b0;
        end
        CELL_REARM: begin
          hit <= 1'b0;
          if (wr) begin
            valid <= 1'b1;
          end
        end
        CELL_STEP:   hit <= step_hit;
        CELL_SETTLE: hit <= settle_hit;
        default: ;
      endcase
    end
  end

endmodule

>>> src/wildcard_regex_matcher_core.sv
`timescale 1ns / 1ps
// Top level of the wildcard regex matcher: control, length, row bit zero, results.
// Depends on wrm_pkg and wrm_cell.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------
//  item     | item_valid / item_ready    | func[1:0], symbol[7:0]
//  result   | result_valid / result_ready| matched, pattern_overflow
//
// Each transaction loads or steps the row of cells, then stays in ST_SETTLE while
// any cell changes; each settle step extends firing chains of stars by one link,
// and such a chain has at most PATTERN_MAX/2 links.
// Reset clears the length, overflow flag, cell valid bits and sets row bit zero.
// A waiting result stalls only an end-of-text transaction.
module wildcard_regex_matcher_core #(
  parameter int PATTERN_MAX = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [1:0] func,
  input  logic [7:0] symbol,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       matched,
  output logic       pattern_overflow
);
  import wrm_pkg::*;

  localparam int LenW = $clog2(PATTERN_MAX + 1);
  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SETTLE = 1'b1;

  logic                  state;
  logic [LenW-1:0]       length;
  logic                  overflow;
  logic                  hit0;
  logic [PATTERN_MAX:0]  row;
  logic [PATTERN_MAX:1]  changed;
  logic [7:0]            pats [PATTERN_MAX:0];
  logic                  accept;
  logic                  full;
  cell_ctrl_t            ctrl;

  assign full       = (length == LenW'(PATTERN_MAX));
  assign item_ready = (state == ST_IDLE) &&
                      ((func != FUNC_END) || !result_valid || result_ready);
  assign accept     = item_valid && item_ready;
  assign row[0]     = hit0;
  assign pats[0]    = 8'h00;

  always_comb begin
    ctrl.sym = symbol;
    ctrl.op  = CELL_HOLD;
    if (state == ST_SETTLE) begin
      ctrl.op = CELL_SETTLE;
    end else if (accept) begin
      unique case (func)
        FUNC_CLEAR:  ctrl.op = CELL_CLEAR;
        FUNC_APPEND: ctrl.op = CELL_REARM;
        FUNC_TEXT:   ctrl.op = CELL_STEP;
        FUNC_END:    ctrl.op = CELL_REARM;
        default:     ctrl.op = CELL_HOLD;
      endcase
    end
  end

  for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
    logic wr;
    logic prev2;
    assign wr = (func == FUNC_APPEND) && (length == LenW'(j - 1));
    if (j == 1) begin : g_first
      assign prev2 = 1'b0;
    end else begin : g_rest
      assign prev2 = row[j-2];
    end
    wrm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .wr       (wr),
      .prev_pat (pats[j-1]),
      .prev_hit (row[j-1]),
      .prev2_hit(prev2),
      .pat      (pats[j]),
      .hit      (row[j]),
      .changed  (changed[j])
    );
  end

  always_ff @(posedge clk) begin
    if (accept && func == FUNC_END) begin
      matched          <= row[length];
      pattern_overflow <= overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      length       <= '0;
      overflow     <= 1'b0;
      hit0         <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      if (accept && func == FUNC_END) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SETTLE;
            hit0  <= (func != FUNC_TEXT);
            case (func)
              FUNC_CLEAR: begin
                length   <= '0;
                overflow <= 1'b0;
              end
              FUNC_APPEND: begin
                if (full) begin
                  overflow <= 1'b1;
                end else begin
                  length <= length + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SETTLE: begin
          if (!(|changed)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_accept_settle: assert property (@(posedge clk) disable iff (rst)
    state == ST_SETTLE |-> !item_ready)
    else $error("item accepted while row settles");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LenW'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && func == FUNC_END |=> result_valid)
    else $error("end of text gave no result");

  a_text_clears_hit0: assert property (@(posedge clk) disable iff (rst)
    accept && func == FUNC_TEXT |=> !hit0)
    else $error("row bit zero set after text byte");

endmodule
